### design/svm_pkg.sv
// svm_pkg: types and constants shared by the stack machine core
// opcode codes, run status codes, config register indexes, fsm states
// no dependencies
package svm_pkg;

    typedef enum logic [5:0] {
        OP_LEA  = 6'd0,  OP_IMM  = 6'd1,  OP_JMP  = 6'd2,  OP_CALL = 6'd3,
        OP_JZ   = 6'd4,  OP_JNZ  = 6'd5,  OP_ENT  = 6'd6,  OP_ADJ  = 6'd7,
        OP_LEV  = 6'd8,  OP_LI   = 6'd9,  OP_SI   = 6'd10, OP_PUSH = 6'd11,
        OP_LOAD = 6'd12, OP_OR   = 6'd13, OP_XOR  = 6'd14, OP_AND  = 6'd15,
        OP_EQ   = 6'd16, OP_NE   = 6'd17, OP_LT   = 6'd18, OP_GT   = 6'd19,
        OP_LE   = 6'd20, OP_GE   = 6'd21, OP_SHL  = 6'd22, OP_SHR  = 6'd23,
        OP_ADD  = 6'd24, OP_SUB  = 6'd25, OP_MUL  = 6'd26, OP_DIV  = 6'd27,
        OP_MOD  = 6'd28, OP_OPEN = 6'd29, OP_READ = 6'd30, OP_CLOS = 6'd31,
        OP_PRTF = 6'd32, OP_MALC = 6'd33, OP_MSET = 6'd34, OP_MCMP = 6'd35,
        OP_EXIT = 6'd36
    } t_opcode;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_EXIT = 2'd1,
        ST_BAD  = 2'd2,
        ST_DIV0 = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_CODE_BASE   = 2'd0,
        CFG_DATA_SEG    = 2'd1,
        CFG_STACK_TOP   = 2'd2,
        CFG_ENTRY_INDEX = 2'd3
    } t_cfg_index;

    localparam logic REQ_PRELOAD = 1'b1;

    localparam logic [31:0] STACK_TOP_RESET = 32'd16384;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               req_type;
        logic [5:0]         opcode;
        logic signed [31:0] operand;
        logic [31:0]        preload_address;
        logic signed [31:0] preload_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        next_pc;
        logic signed [31:0] accumulator;
        logic [31:0]        stack_pointer_out;
        logic [1:0]         run_status;
    } t_out_item;

    typedef struct packed {
        logic clr_step;
        logic take;
        logic rd1;
        logic rd2;
        logic exec;
        logic div_step;
        logic div_commit;
        logic out_load;
    } t_ctl;

    typedef struct packed {
        logic clr_done;
        logic is_lev;
        logic needs_div;
        logic div_done;
    } t_sts;

endpackage

### design/svm_ctrl.sv
// svm_ctrl: sequencing state machine of the stack machine core
// drives datapath commands and both handshakes; uses svm_pkg
module svm_ctrl
    import svm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctl       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    o_ctl.take = 1'b1;
                    n_state    = S_RD1;
                end
            end
            S_RD1: begin
                o_ctl.rd1 = 1'b1;
                n_state   = i_sts.is_lev ? S_RD2 : S_EXEC;
            end
            S_RD2: begin
                o_ctl.rd2 = 1'b1;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = i_sts.needs_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_ctl.div_commit = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_ctl.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

### design/svm_datapath.sv
// svm_datapath: machine registers, word memory, alu and iterative divider
// acts on commands from svm_ctrl; uses svm_pkg
module svm_datapath
    import svm_pkg::*;
#(
    parameter int MEM_WORDS = 4096,
    parameter int SEG_BYTES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctl       i_ctl,
    output t_sts       o_sts,
    input  t_in_item   i_in_item,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_out_item  o_out_item
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [31:0] SEG_MASK = 32'(SEG_BYTES - 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(MEM_WORDS - 1);

    logic [31:0] r_mem [MEM_WORDS];
    logic [31:0] r_rdata, r_t;

    logic [31:0] r_code_base, r_data_seg, r_stack_top;
    logic [29:0] r_entry;
    logic [31:0] r_pc, r_acc, r_bp, r_sp;
    t_status     r_status;
    logic        r_started;
    logic [AW-1:0] r_clr_idx;

    logic [31:0] n_code_base, n_data_seg, n_stack_top;
    logic [29:0] n_entry;
    logic [31:0] n_pc, n_acc, n_bp, n_sp;
    t_status     n_status;
    logic        n_started;

    logic        r_req;
    t_opcode     r_op;
    logic [31:0] r_opnd, r_pl_addr, r_pl_val;

    logic [31:0] r_quo, r_rem, r_ub;
    logic        r_na, r_nb, r_want_mod;
    logic [5:0]  r_cnt;
    logic [32:0] div_tmp, div_diff;
    logic [31:0] div_res, ub;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata;

    t_status     halt_code;
    logic        running, needs_div, commit;
    logic [31:0] pc0, target, opnd4, t, sp_push;

    assign running   = (r_req != REQ_PRELOAD) && (r_status == ST_RUN);
    assign needs_div = running && (r_op == OP_DIV || r_op == OP_MOD) && (r_acc != '0);
    assign commit    = (i_ctl.exec && !needs_div) || i_ctl.div_commit;

    assign o_sts.clr_done  = (r_clr_idx == LAST_IDX);
    assign o_sts.is_lev    = running && (r_op == OP_LEV);
    assign o_sts.needs_div = needs_div;
    assign o_sts.div_done  = (r_cnt == 6'd32);

    assign t       = r_rdata;
    assign opnd4   = {r_opnd[29:0], 2'b00};
    assign pc0     = r_pc + 32'd4;
    assign target  = r_code_base + opnd4;
    assign sp_push = r_sp - 32'd4;

    always_comb begin
        unique case (r_op)
            OP_EXIT: halt_code = ST_EXIT;
            OP_OPEN, OP_READ, OP_CLOS, OP_PRTF, OP_MALC, OP_MSET, OP_MCMP:
                halt_code = ST_BAD;
            OP_DIV, OP_MOD: halt_code = (r_acc == '0) ? ST_DIV0 : ST_RUN;
            OP_LEA, OP_IMM, OP_JMP, OP_CALL, OP_JZ, OP_JNZ, OP_ENT, OP_ADJ,
            OP_LEV, OP_LI, OP_SI, OP_PUSH, OP_LOAD, OP_OR, OP_XOR, OP_AND,
            OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE, OP_SHL, OP_SHR,
            OP_ADD, OP_SUB, OP_MUL: halt_code = ST_RUN;
            default: halt_code = ST_BAD;
        endcase
    end

    // divider
    assign ub       = r_acc[31] ? (32'd0 - r_acc) : r_acc;
    assign div_tmp  = {r_rem, r_quo[31]};
    assign div_diff = div_tmp - {1'b0, r_ub};
    assign div_res  = r_want_mod ? (r_na ? (32'd0 - r_rem) : r_rem)
                                 : ((r_na ^ r_nb) ? (32'd0 - r_quo) : r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd32;
        end else if (i_ctl.exec && needs_div) begin
            r_cnt <= '0;
        end else if (i_ctl.div_step) begin
            r_cnt <= r_cnt + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && needs_div) begin
            r_na       <= t[31];
            r_nb       <= r_acc[31];
            r_ub       <= ub;
            r_quo      <= t[31] ? (32'd0 - t) : t;
            r_rem      <= '0;
            r_want_mod <= (r_op == OP_MOD);
        end else if (i_ctl.div_step) begin
            if (!div_diff[32]) begin
                r_rem <= div_diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= div_tmp[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_req     <= i_in_item.req_type;
            r_op      <= t_opcode'(i_in_item.opcode);
            r_opnd    <= i_in_item.operand;
            r_pl_addr <= i_in_item.preload_address;
            r_pl_val  <= i_in_item.preload_value;
        end
    end

    // memory port
    always_comb begin
        re    = i_ctl.rd1 || i_ctl.rd2;
        raddr = r_sp[AW+1:2];
        if (i_ctl.rd2) begin
            raddr = r_bp[AW+1:2] + AW'(1);
        end else if (r_op == OP_LI) begin
            raddr = r_acc[AW+1:2];
        end else if (r_op == OP_LEV) begin
            raddr = r_bp[AW+1:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
        if (i_ctl.rd2) begin
            r_t <= r_rdata;
        end
    end

    always_comb begin
        n_code_base = r_code_base;
        n_data_seg  = r_data_seg;
        n_stack_top = r_stack_top;
        n_entry     = r_entry;
        n_pc        = r_pc;
        n_acc       = r_acc;
        n_bp        = r_bp;
        n_sp        = r_sp;
        n_status    = r_status;
        n_started   = r_started;
        we          = 1'b0;
        waddr       = r_clr_idx;
        wdata       = '0;

        if (i_ctl.clr_step) begin
            we = 1'b1;
        end

        if (commit) begin
            if (r_req == REQ_PRELOAD) begin
                we    = 1'b1;
                waddr = r_pl_addr[AW+1:2];
                wdata = r_pl_val;
            end else if (r_status == ST_RUN) begin
                n_started = 1'b1;
                if (halt_code != ST_RUN) begin
                    n_status = halt_code;
                end else begin
                    n_pc = pc0;
                    unique case (r_op)
                        OP_LEA: begin
                            n_acc = r_bp + r_opnd;
                            n_pc  = pc0 + 32'd4;
                        end
                        OP_IMM: begin
                            n_acc = r_opnd;
                            n_pc  = pc0 + 32'd4;
                        end
                        OP_JMP: n_pc = target;
                        OP_CALL: begin
                            we    = 1'b1;
                            waddr = sp_push[AW+1:2];
                            wdata = pc0 + 32'd4;
                            n_sp  = sp_push;
                            n_pc  = target;
                        end
                        OP_JZ:  n_pc = (r_acc != '0) ? pc0 + 32'd4 : target;
                        OP_JNZ: n_pc = (r_acc != '0) ? target : pc0 + 32'd4;
                        OP_ENT: begin
                            we    = 1'b1;
                            waddr = sp_push[AW+1:2];
                            wdata = r_bp;
                            n_bp  = sp_push;
                            n_sp  = sp_push - opnd4;
                            n_pc  = pc0 + 32'd4;
                        end
                        OP_ADJ: begin
                            n_sp = r_sp + opnd4;
                            n_pc = pc0 + 32'd4;
                        end
                        OP_LEV: begin
                            n_sp = r_bp + 32'd8;
                            n_bp = r_t;
                            n_pc = r_rdata;
                        end
                        OP_LI: n_acc = r_rdata;
                        OP_SI: begin
                            we    = 1'b1;
                            waddr = t[AW+1:2];
                            wdata = r_acc;
                            n_sp  = r_sp + 32'd4;
                        end
                        OP_PUSH: begin
                            we    = 1'b1;
                            waddr = sp_push[AW+1:2];
                            wdata = r_acc;
                            n_sp  = sp_push;
                        end
                        OP_LOAD: n_acc = r_data_seg | ({r_acc[29:0], 2'b00} & SEG_MASK);
                        default: begin
                            n_sp = r_sp + 32'd4;
                            unique case (r_op)
                                OP_OR:  n_acc = t | r_acc;
                                OP_XOR: n_acc = t ^ r_acc;
                                OP_AND: n_acc = t & r_acc;
                                OP_EQ:  n_acc = {31'd0, t == r_acc};
                                OP_NE:  n_acc = {31'd0, t != r_acc};
                                OP_LT:  n_acc = {31'd0, $signed(t) < $signed(r_acc)};
                                OP_GT:  n_acc = {31'd0, $signed(r_acc) < $signed(t)};
                                OP_LE:  n_acc = {31'd0, !($signed(r_acc) < $signed(t))};
                                OP_GE:  n_acc = {31'd0, !($signed(t) < $signed(r_acc))};
                                OP_SHL: n_acc = t << r_acc[4:0];
                                OP_SHR: n_acc = 32'($signed(t) >>> r_acc[4:0]);
                                OP_ADD: n_acc = t + r_acc;
                                OP_SUB: n_acc = t - r_acc;
                                OP_MUL: n_acc = 32'(t * r_acc);
                                default: n_acc = div_res;
                            endcase
                        end
                    endcase
                end
            end
        end

        if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CODE_BASE:   n_code_base = i_cfg_data;
                CFG_DATA_SEG:    n_data_seg  = i_cfg_data;
                CFG_STACK_TOP:   n_stack_top = i_cfg_data;
                CFG_ENTRY_INDEX: n_entry     = i_cfg_data[29:0];
                default: ;
            endcase
            if (!r_started) begin
                n_pc = n_code_base + {n_entry, 2'b00};
                n_sp = n_stack_top;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_base <= '0;
            r_data_seg  <= '0;
            r_stack_top <= STACK_TOP_RESET;
            r_entry     <= '0;
            r_pc        <= '0;
            r_acc       <= '0;
            r_bp        <= '0;
            r_sp        <= STACK_TOP_RESET;
            r_status    <= ST_RUN;
            r_started   <= 1'b0;
            r_clr_idx   <= '0;
        end else begin
            r_code_base <= n_code_base;
            r_data_seg  <= n_data_seg;
            r_stack_top <= n_stack_top;
            r_entry     <= n_entry;
            r_pc        <= n_pc;
            r_acc       <= n_acc;
            r_bp        <= n_bp;
            r_sp        <= n_sp;
            r_status    <= n_status;
            r_started   <= n_started;
            if (i_ctl.clr_step && (r_clr_idx != LAST_IDX)) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            o_out_item.next_pc           <= r_pc;
            o_out_item.accumulator       <= r_acc;
            o_out_item.stack_pointer_out <= r_sp;
            o_out_item.run_status        <= r_status;
        end
    end

endmodule

### design/stack_vm_instruction_execute.sv
// stack_vm_instruction_execute: top level of the accumulator stack machine core
// joins svm_ctrl and svm_datapath; uses svm_pkg
//
// Each input transfer either executes one instruction (opcode plus operand) or preloads
// one word of the flat word memory, and gives exactly one result transfer with the next
// fetch address, ax, sp and the run status. After reset a clearing pass zeroes the word
// memory one word per cycle, so no item is taken until every word is cleared;
// configuration writes are taken at any time. An item then passes through accept, memory
// read, execute and output, with a second read for LEV, whose two pops share the single
// memory read port, and one-bit-per-cycle divider steps for DIV and MOD with a nonzero
// divisor. The user keeps MEM_WORDS and SEG_BYTES powers of two; the block does not check.
module stack_vm_instruction_execute
    import svm_pkg::*;
#(
    parameter int MEM_WORDS = 4096,
    parameter int SEG_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_ctl ctl;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    svm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    svm_datapath #(
        .MEM_WORDS (MEM_WORDS),
        .SEG_BYTES (SEG_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_item  (o_out_item)
    );

endmodule

### test/svm_exec_checker.sv
// svm_exec_checker: watches the stack machine channels, predicts each result and compares
// keeps its own copy of the machine state, config registers and word memory
// depends on svm_pkg
module svm_exec_checker
    import svm_pkg::*;
#(
    parameter int MEM_WORDS = 4096,
    parameter int SEG_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_item,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] code_base, data_seg, stack_top;
    logic [29:0] entry_index;
    logic [31:0] pc, ax, bp, sp;
    t_status     run_state;
    logic        started;
    logic [31:0] mem [MEM_WORDS];
    t_out_item   expected_results[$];
    int          fails;

    function automatic int word_index(logic [31:0] a);
        return int'((a >> 2) & (MEM_WORDS - 1));
    endfunction

    function automatic logic [31:0] pop_word();
        logic [31:0] v;
        v = mem[word_index(sp)];
        sp = sp + 32'd4;
        return v;
    endfunction

    function automatic void push_word(logic [31:0] v);
        sp = sp - 32'd4;
        mem[word_index(sp)] = v;
    endfunction

    function automatic logic [31:0] signed_divide(logic [31:0] a, logic [31:0] b, bit want_rem);
        logic [31:0] ua, ub, q, r;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q  = ua / ub;
        r  = ua % ub;
        if (want_rem) return a[31] ? -r : r;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function automatic void run_instruction(logic [5:0] op, logic [31:0] opnd);
        logic [31:0] npc, target, t;
        npc    = pc + 32'd4;
        target = code_base + opnd * 32'd4;
        if (op >= OP_OPEN && op <= OP_MCMP) begin
            run_state = ST_BAD;
            return;
        end
        if (op == OP_EXIT) begin
            run_state = ST_EXIT;
            return;
        end
        if (op > OP_EXIT) begin
            run_state = ST_BAD;
            return;
        end
        if ((op == OP_DIV || op == OP_MOD) && ax == 0) begin
            run_state = ST_DIV0;
            return;
        end
        case (op)
            OP_LEA: begin
                ax = bp + opnd;
                npc += 4;
            end
            OP_IMM: begin
                ax = opnd;
                npc += 4;
            end
            OP_JMP: npc = target;
            OP_CALL: begin
                push_word(npc + 32'd4);
                npc = target;
            end
            OP_JZ: npc = (ax != 0) ? npc + 32'd4 : target;
            OP_JNZ: npc = (ax != 0) ? target : npc + 32'd4;
            OP_ENT: begin
                push_word(bp);
                bp = sp;
                sp = sp - opnd * 32'd4;
                npc += 4;
            end
            OP_ADJ: begin
                sp = sp + opnd * 32'd4;
                npc += 4;
            end
            OP_LEV: begin
                sp  = bp;
                bp  = pop_word();
                npc = pop_word();
            end
            OP_LI: ax = mem[word_index(ax)];
            OP_SI: begin
                t = pop_word();
                mem[word_index(t)] = ax;
            end
            OP_PUSH: push_word(ax);
            OP_LOAD: ax = data_seg | ((ax * 32'd4) & (SEG_BYTES - 1));
            default: begin
                t = pop_word();
                case (op)
                    OP_OR:  ax = t | ax;
                    OP_XOR: ax = t ^ ax;
                    OP_AND: ax = t & ax;
                    OP_EQ:  ax = {31'd0, t == ax};
                    OP_NE:  ax = {31'd0, t != ax};
                    OP_LT:  ax = {31'd0, $signed(t) < $signed(ax)};
                    OP_GT:  ax = {31'd0, $signed(t) > $signed(ax)};
                    OP_LE:  ax = {31'd0, $signed(t) <= $signed(ax)};
                    OP_GE:  ax = {31'd0, $signed(t) >= $signed(ax)};
                    OP_SHL: ax = t << ax[4:0];
                    OP_SHR: ax = $unsigned($signed(t) >>> ax[4:0]);
                    OP_ADD: ax = t + ax;
                    OP_SUB: ax = t - ax;
                    OP_MUL: ax = t * ax;
                    OP_DIV: ax = signed_divide(t, ax, 1'b0);
                    default: ax = signed_divide(t, ax, 1'b1);
                endcase
            end
        endcase
        pc = npc;
    endfunction

    function automatic t_out_item predict_step(t_in_item it);
        t_out_item r;
        if (it.req_type == REQ_PRELOAD) begin
            mem[word_index(it.preload_address)] = it.preload_value;
        end else if (run_state == ST_RUN) begin
            started = 1'b1;
            run_instruction(it.opcode, it.operand);
        end
        r.next_pc           = pc;
        r.accumulator       = ax;
        r.stack_pointer_out = sp;
        r.run_status        = run_state;
        return r;
    endfunction

    function automatic void write_register(logic [1:0] idx, logic [31:0] v);
        case (t_cfg_index'(idx))
            CFG_CODE_BASE:   code_base = v;
            CFG_DATA_SEG:    data_seg = v;
            CFG_STACK_TOP:   stack_top = v;
            CFG_ENTRY_INDEX: entry_index = v[29:0];
            default: ;
        endcase
        if (!started) begin
            pc = code_base + {entry_index, 2'b00};
            sp = stack_top;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            code_base   = 0;
            data_seg    = 0;
            stack_top   = STACK_TOP_RESET;
            entry_index = 0;
            pc          = 0;
            ax          = 0;
            bp          = 0;
            sp          = STACK_TOP_RESET;
            run_state   = ST_RUN;
            started     = 1'b0;
            for (int k = 0; k < MEM_WORDS; k++) mem[k] = 0;
            expected_results.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_index, i_cfg_data);
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expected result");
                    fails++;
                end else begin
                    e = expected_results.pop_front();
                    if (i_out_item.next_pc !== e.next_pc) begin
                        $error("next_pc: expected %h, got %h", e.next_pc, i_out_item.next_pc);
                        fails++;
                    end
                    if (i_out_item.accumulator !== e.accumulator) begin
                        $error("accumulator: expected %h, got %h",
                               e.accumulator, i_out_item.accumulator);
                        fails++;
                    end
                    if (i_out_item.stack_pointer_out !== e.stack_pointer_out) begin
                        $error("stack_pointer_out: expected %h, got %h",
                               e.stack_pointer_out, i_out_item.stack_pointer_out);
                        fails++;
                    end
                    if (i_out_item.run_status !== e.run_status) begin
                        $error("run_status: expected %0d, got %0d",
                               e.run_status, i_out_item.run_status);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) expected_results.push_back(predict_step(i_in_item));
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

### test/tb_stack_vm_instruction_execute.sv
// tb_stack_vm_instruction_execute: stimulus and verdict for the stack machine core
// drives directed and random instruction streams under varied idling and config settings
// depends on svm_pkg, svm_exec_checker and the core
module tb_stack_vm_instruction_execute
    import svm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          gap_pct;
    int          stall_pct;
    bit          long_hold;
    int          hold_count;

    stack_vm_instruction_execute dut (.*);

    svm_exec_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_item(i_in_item),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (long_hold && (hold_count < 400)) begin
            i_out_stall <= 1'b1;
            hold_count  <= hold_count + 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            if (!long_hold) hold_count <= 0;
        end
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_item(t_in_item it);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic exec_op(t_opcode op, logic [31:0] opnd);
        t_in_item it;
        it.req_type        = ~REQ_PRELOAD;
        it.opcode          = op;
        it.operand         = opnd;
        it.preload_address = $urandom;
        it.preload_value   = $urandom;
        send_item(it);
    endtask

    task automatic preload_word(logic [31:0] addr, logic [31:0] val);
        t_in_item it;
        it.req_type        = REQ_PRELOAD;
        it.opcode          = $urandom_range(0, 63);
        it.operand         = $urandom;
        it.preload_address = addr;
        it.preload_value   = val;
        send_item(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] nonzero_word();
        logic [31:0] v;
        do v = $urandom; while (v == 0);
        return v;
    endfunction

    function automatic logic [31:0] small_word();
        return $urandom_range(0, 1) ? $urandom_range(0, 16) : -$urandom_range(0, 16);
    endfunction

    task automatic random_program(int n);
        int count;
        count = 0;
        while (count < n) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    exec_op(OP_IMM, $urandom);
                    exec_op(OP_PUSH, $urandom);
                    exec_op(OP_IMM, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40));
                    exec_op(t_opcode'($urandom_range(OP_OR, OP_MUL)), $urandom);
                    count += 4;
                end
                2: begin
                    exec_op(OP_IMM, $urandom);
                    exec_op(OP_PUSH, $urandom);
                    exec_op(OP_IMM, $urandom_range(0, 1) ? nonzero_word()
                                                         : $urandom_range(1, 9));
                    exec_op($urandom_range(0, 1) ? OP_DIV : OP_MOD, $urandom);
                    count += 4;
                end
                3: begin
                    exec_op(OP_ENT, small_word());
                    exec_op(OP_LEA, small_word());
                    exec_op(OP_PUSH, $urandom);
                    exec_op(OP_ADJ, small_word());
                    exec_op(OP_LEV, $urandom);
                    count += 5;
                end
                4: begin
                    exec_op(t_opcode'($urandom_range(OP_JMP, OP_JNZ)), $urandom);
                    count += 1;
                end
                5: begin
                    exec_op(OP_IMM, $urandom);
                    exec_op(OP_PUSH, $urandom);
                    exec_op(OP_IMM, $urandom);
                    exec_op(OP_SI, $urandom);
                    exec_op(OP_LI, $urandom);
                    exec_op(OP_LOAD, $urandom);
                    count += 6;
                end
                6: begin
                    preload_word($urandom, $urandom);
                    count += 1;
                end
                default: begin
                    exec_op(t_opcode'($urandom_range(OP_LEA, OP_MUL)),
                            $urandom_range(0, 1) ? $urandom : small_word());
                    count += 1;
                end
            endcase
        end
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CODE_BASE;
        i_cfg_data  = '0;
        gap_pct     = 0;
        stall_pct   = 0;
        long_hold   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extreme settings before start, then settle on a working set
        write_reg(CFG_CODE_BASE, 32'hFFFF_FFFF);
        write_reg(CFG_DATA_SEG, 32'hFFFF_FFFF);
        write_reg(CFG_STACK_TOP, 32'h0000_0000);
        write_reg(CFG_ENTRY_INDEX, 32'h3FFF_FFFF);
        preload_word(32'hFFFF_FFFF, 32'h8000_0000);
        drain();
        write_reg(CFG_ENTRY_INDEX, 32'd0);
        write_reg(CFG_CODE_BASE, 32'h0000_0000);
        write_reg(CFG_STACK_TOP, 32'hFFFF_FFFC);
        write_reg(CFG_DATA_SEG, 32'h0000_1000);

        preload_word(32'h0000_0000, 32'h7FFF_FFFF);
        exec_op(OP_IMM, 32'h7FFF_FFFF);
        exec_op(OP_PUSH, 32'h0);
        exec_op(OP_IMM, 32'h0000_0001);
        exec_op(OP_ADD, 32'h0);
        exec_op(OP_PUSH, 32'h0);
        exec_op(OP_IMM, 32'hFFFF_FFFF);
        exec_op(OP_DIV, 32'h0);
        exec_op(OP_IMM, 32'h8000_0000);
        exec_op(OP_PUSH, 32'h0);
        exec_op(OP_IMM, 32'hFFFF_FFFF);
        exec_op(OP_MOD, 32'h0);
        exec_op(OP_PUSH, 32'h0);
        exec_op(OP_IMM, 32'd63);
        exec_op(OP_SHR, 32'h0);
        exec_op(OP_SHL, 32'h0);
        exec_op(OP_JZ, 32'h8000_0000);
        exec_op(OP_JNZ, 32'h7FFF_FFFF);
        exec_op(OP_CALL, 32'h0000_0010);
        exec_op(OP_ENT, 32'h0000_0002);
        exec_op(OP_LEA, 32'h8000_0000);
        exec_op(OP_LOAD, 32'h0);
        exec_op(OP_LI, 32'h0);
        exec_op(OP_LEV, 32'h0);
        exec_op(OP_ADJ, 32'hFFFF_FFFF);
        exec_op(OP_JMP, 32'h0);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin
                    gap_pct = 52;
                    stall_pct = 0;
                end
                2: begin
                    gap_pct = 0;
                    stall_pct = 52;
                end
                3: begin
                    gap_pct = 22;
                    stall_pct = 22;
                end
                default: begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
            endcase
            write_reg(t_cfg_index'($urandom_range(0, 3)), $urandom);
            write_reg(CFG_DATA_SEG, $urandom_range(0, 1) ? 32'h0 : $urandom);
            if (phase == 4) long_hold = 1'b1;
            random_program(150);
            if (phase == 4) begin
                drain();
                long_hold = 1'b0;
            end
            random_program(150);
            drain();
        end

        // one halt, then items while halted
        case ($urandom_range(0, 2))
            0: exec_op(OP_EXIT, $urandom);
            1: exec_op(t_opcode'($urandom_range(OP_OPEN, 63)), $urandom);
            default: begin
                exec_op(OP_IMM, 32'h0);
                exec_op($urandom_range(0, 1) ? OP_DIV : OP_MOD, $urandom);
            end
        endcase
        gap_pct = 22;
        stall_pct = 22;
        for (int k = 0; k < 24; k++) begin
            if ($urandom_range(0, 2) == 0) preload_word($urandom, $urandom);
            else exec_op(t_opcode'($urandom_range(0, 63)), $urandom);
        end
        drain();
        write_reg(CFG_ENTRY_INDEX, $urandom);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
